### rtl/mdet_pkg.sv
package mdet_pkg;

  localparam int ElemW = 16;
  localparam int ResW  = 64;
  localparam int CfgW  = 3;

  typedef struct packed {
    logic [1:0]              row_index;
    logic [1:0]              col_index;
    logic signed [ElemW-1:0] element_value;
    logic                    last_element;
  } cmd_t;

  typedef struct packed {
    logic signed [ResW-1:0] determinant;
    logic                   overflow;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_NEXT,
    ST_SHIFT,
    ST_SAT
  } state_e;

endpackage

### rtl/mdet_store.sv
module mdet_store #(
  parameter int MAX_N = 4
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] waddr_i,
  input  logic signed [mdet_pkg::ElemW-1:0]         wdata_i,
  input  logic [((MAX_N > 1) ? $clog2(MAX_N*MAX_N) : 1)-1:0] raddr_i,
  output logic signed [mdet_pkg::ElemW-1:0]         rdata_o
);

  localparam int Depth = MAX_N * MAX_N;

  logic signed [mdet_pkg::ElemW-1:0] mem_q [Depth];

  // element memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/matrix_determinant_core.sv
// Channel   Direction  Handshake                 Payload
// command   in         start_i / busy_o          cmd_i (row, column, value, last)
// result    out        done_o (one-cycle strobe)  res_o (determinant, overflow)
// config    in         cfg_valid_i / cfg_ready_o cfg_data_i (matrix order)
//
// A non-last element is stored in the transfer cycle; busy_o stays low.
// A last element starts the Leibniz sum over all n^n column tuples, skipping
// non-permutations. One shared shift-add multiplier forms each term. Reset
// clears control only; the result strobe cannot be stalled by the receiver.
module matrix_determinant_core #(
  parameter int MAX_N = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  mdet_pkg::cmd_t               cmd_i,
  output logic                         done_o,
  output mdet_pkg::res_t               res_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mdet_pkg::CfgW-1:0]    cfg_data_i
);

  localparam int NW    = $clog2(MAX_N + 1);
  localparam int DW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int AddrW = (MAX_N > 1) ? $clog2(MAX_N * MAX_N) : 1;
  localparam int PW    = 16 * MAX_N;
  localparam int AW    = PW + 8;
  localparam int SW    = (AW + 8 > 65) ? AW + 8 : 65;
  localparam int RW    = mdet_pkg::ResW;

  mdet_pkg::state_e state_q, state_d;

  logic [mdet_pkg::CfgW-1:0] size_q;
  logic [NW-1:0]             n_q, n_d, n_cfg;
  logic [DW-1:0]             dig_q [MAX_N];
  logic [DW-1:0]             dig_d [MAX_N];
  logic [DW-1:0]             k_q, k_d;
  logic [3:0]                bit_q, bit_d;
  logic signed [PW-1:0]      prod_q, prod_d;
  logic signed [PW-1:0]      part_q, part_d;
  logic signed [PW-1:0]      mcand_q, mcand_d;
  logic signed [AW-1:0]      acc_q, acc_d;
  logic signed [SW-1:0]      sh_q, sh_d, acc_ext;
  logic                      done_q, done_d;
  mdet_pkg::res_t            res_q, res_d;

  logic                      accept, we;
  logic [AddrW-1:0]          waddr, raddr;
  logic signed [mdet_pkg::ElemW-1:0] rdata;
  logic                      perm_ok, odd, wrap, carry;
  logic [NW+2:0]             shamt;
  logic [SW-RW:0]            top_bits;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != mdet_pkg::ST_IDLE);
  assign cfg_ready_o = !busy_o;
  assign done_o      = done_q;
  assign res_o       = res_q;

  // store write and read addresses
  assign we    = accept && (int'(cmd_i.row_index) < MAX_N) && (int'(cmd_i.col_index) < MAX_N);
  assign waddr = AddrW'(int'(cmd_i.row_index) * MAX_N + int'(cmd_i.col_index));
  assign raddr = AddrW'(int'(k_q) * MAX_N + int'(dig_q[k_q]));

  mdet_store #(.MAX_N(MAX_N)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(cmd_i.element_value),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // clamp the configured order into 1..MAX_N
  always_comb begin
    if (size_q == '0) begin
      n_cfg = NW'(1);
    end else if (int'(size_q) > MAX_N) begin
      n_cfg = NW'(MAX_N);
    end else begin
      n_cfg = NW'(size_q);
    end
  end

  // tuple is a permutation; inversion parity gives the sign
  always_comb begin
    perm_ok = 1'b1;
    odd     = 1'b0;
    for (int i = 0; i < MAX_N; i++) begin
      for (int j = i + 1; j < MAX_N; j++) begin
        if (j < int'(n_q)) begin
          if (dig_q[i] == dig_q[j]) perm_ok = 1'b0;
          if (dig_q[i] > dig_q[j]) odd = ~odd;
        end
      end
    end
  end

  // mixed-radix tuple counter
  always_comb begin
    carry = 1'b1;
    for (int k = 0; k < MAX_N; k++) begin
      dig_d[k] = dig_q[k];
      if (k < int'(n_q) && carry) begin
        if (NW'(dig_q[k]) == n_q - NW'(1)) begin
          dig_d[k] = '0;
        end else begin
          dig_d[k] = dig_q[k] + DW'(1);
          carry    = 1'b0;
        end
      end
    end
    wrap = carry;
  end

  assign acc_ext  = SW'(acc_q);
  assign shamt    = {n_q - NW'(2), 3'b000};
  assign top_bits = sh_q[SW-1:RW-1];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mdet_pkg::ST_IDLE:  if (accept && cmd_i.last_element) state_d = mdet_pkg::ST_CHECK;
      mdet_pkg::ST_CHECK: state_d = perm_ok ? mdet_pkg::ST_LOAD : mdet_pkg::ST_NEXT;
      mdet_pkg::ST_LOAD:  state_d = mdet_pkg::ST_MUL;
      mdet_pkg::ST_MUL: begin
        if (bit_q == 4'd15) begin
          state_d = (NW'(k_q) == n_q - NW'(1)) ? mdet_pkg::ST_ADD : mdet_pkg::ST_LOAD;
        end
      end
      mdet_pkg::ST_ADD:   state_d = mdet_pkg::ST_NEXT;
      mdet_pkg::ST_NEXT:  state_d = wrap ? mdet_pkg::ST_SHIFT : mdet_pkg::ST_CHECK;
      mdet_pkg::ST_SHIFT: state_d = mdet_pkg::ST_SAT;
      mdet_pkg::ST_SAT:   state_d = mdet_pkg::ST_IDLE;
      default:            state_d = mdet_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    n_d     = n_q;
    k_d     = k_q;
    bit_d   = bit_q;
    prod_d  = prod_q;
    part_d  = part_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    sh_d    = sh_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      mdet_pkg::ST_IDLE: begin
        n_d   = n_cfg;
        acc_d = '0;
      end
      mdet_pkg::ST_CHECK: begin
        prod_d = PW'(1);
        k_d    = '0;
      end
      mdet_pkg::ST_LOAD: begin
        mcand_d = prod_q;
        part_d  = '0;
        bit_d   = '0;
      end
      mdet_pkg::ST_MUL: begin
        // shift-add step; the sign bit of the element weighs negative
        if (rdata[bit_q]) begin
          part_d = (bit_q == 4'd15) ? part_q - mcand_q : part_q + mcand_q;
        end
        mcand_d = mcand_q <<< 1;
        bit_d   = bit_q + 4'd1;
        if (bit_q == 4'd15) begin
          prod_d = part_d;
          k_d    = k_q + DW'(1);
        end
      end
      mdet_pkg::ST_ADD: begin
        acc_d = odd ? acc_q - AW'(prod_q) : acc_q + AW'(prod_q);
      end
      mdet_pkg::ST_SHIFT: begin
        // 8n fraction bits down to 16
        if (n_q == NW'(1)) begin
          sh_d = acc_ext <<< 8;
        end else begin
          sh_d = acc_ext >>> shamt;
        end
      end
      mdet_pkg::ST_SAT: begin
        done_d = 1'b1;
        if ((&top_bits) || !(|top_bits)) begin
          res_d.determinant = sh_q[RW-1:0];
          res_d.overflow    = 1'b0;
        end else begin
          res_d.determinant = sh_q[SW-1] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
          res_d.overflow    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdet_pkg::ST_IDLE;
      size_q  <= mdet_pkg::CfgW'(4);
      done_q  <= 1'b0;
      for (int k = 0; k < MAX_N; k++) dig_q[k] <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) size_q <= cfg_data_i;
      for (int k = 0; k < MAX_N; k++) begin
        if (state_q == mdet_pkg::ST_IDLE) begin
          dig_q[k] <= '0;
        end else if (state_q == mdet_pkg::ST_NEXT) begin
          dig_q[k] <= dig_d[k];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    k_q     <= k_d;
    bit_q   <= bit_d;
    prod_q  <= prod_d;
    part_q  <= part_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    sh_q    <= sh_d;
    res_q   <= res_d;
  end

endmodule

### rtl/mdet_checker.sv
module mdet_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input mdet_pkg::cmd_t cmd_i,
  input logic           done_o,
  input mdet_pkg::res_t res_o
);

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o held longer than one cycle");

  // a result follows a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without computation");

  // a plain element transfer does not start a computation
  a_load_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cmd_i.last_element) |=> !busy_o)
    else $error("busy after non-last element");

  // saturation gives one of the two limits
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.overflow) |->
      (res_o.determinant == 64'sh7FFF_FFFF_FFFF_FFFF ||
       res_o.determinant == 64'sh8000_0000_0000_0000))
    else $error("overflow without saturated value");

endmodule

bind matrix_determinant_core mdet_checker u_mdet_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .busy_o (busy_o),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);
